[design/qte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: shared package
// Constants, widths and the arctangent table used by the converter.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int ANGLE_FRACTION_BITS = 13;
  localparam int CORDIC_STAGES       = 16;
  localparam int NORM_BITS           = 30;

  localparam int QUAT_W  = 32;
  localparam int PROD_W  = 64;
  localparam int LEN_W   = 7;
  localparam int CIN_W   = 32;
  localparam int CX_W    = 36;
  localparam int ANG_W   = 64;
  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;
  localparam int YAW_W   = 16;

  // Front end stages: prescale, products, sums, magnitudes, bit length, rescale.
  localparam int FRONT_STAGES = 6;
  localparam int CORDIC_LAT   = CORDIC_STAGES + 1;
  localparam int PIPE_DEPTH   = FRONT_STAGES + CORDIC_LAT + 1 + CORDIC_LAT + 1;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q60    = 64'sh1921FB54442D1846;
  localparam logic signed [ANG_W-1:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;
  localparam logic [31:0]             INV_GAIN_Q32   = 32'h9B74EDA8;

  // Restoring division, evaluated at elaboration only.
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60 from the truncated Taylor series.
  function automatic logic signed [ANG_W-1:0] atan_q60(input int i);
    logic signed [ANG_W-1:0] sum;
    logic [63:0]             term;
    int                      e;
    sum = '0;
    if (i == 0) return QUARTER_PI_Q60;
    for (int k = 0; k < 31; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        term = udiv(64'd1 << (60 - e), 64'(2 * k + 1));
        if ((k & 1) == 1) sum = sum - signed'(term);
        else sum = sum + signed'(term);
      end
    end
    return sum;
  endfunction

endpackage

[design/qte_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion request channel
// Valid/ready channel carrying one quaternion of four signed Q30 components.
// ----------------------------------------------------------------------------
interface qte_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qte_pkg::QUAT_W-1:0]    quat_w;
  logic signed [qte_pkg::QUAT_W-1:0]    quat_x;
  logic signed [qte_pkg::QUAT_W-1:0]    quat_y;
  logic signed [qte_pkg::QUAT_W-1:0]    quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

[design/qte_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler angle result channel
// Valid/ready channel carrying roll, pitch and yaw in radians.
// ----------------------------------------------------------------------------
interface qte_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qte_pkg::ROLL_W-1:0]    roll_angle;
  logic signed [qte_pkg::PITCH_W-1:0]   pitch_angle;
  logic signed [qte_pkg::YAW_W-1:0]     yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

[design/quaternion_to_euler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion to Euler angles (Z-Y-X)
// Throughput one request a cycle while no result waits to be taken.
// The depth is set by two 17-stage CORDIC engines in series (roll and yaw in
// parallel, then pitch), a 6-stage front end, the length scaling multiply and
// the output register.
// The whole pipeline stalls together while a result waits to be taken.
// Reset clears the valid bits only; no request is lost or repeated by a stall.
// ----------------------------------------------------------------------------
module quaternion_to_euler (
  input  logic            clk,
  input  logic            rst,
  qte_in_if.sink          quat_in,
  qte_out_if.source       angles_out
);

  localparam int D  = qte_pkg::PIPE_DEPTH;
  localparam int DL = qte_pkg::CORDIC_LAT + 1;

  logic         en;
  logic [D-1:0] vld;

  assign en            = !vld[D-1] || angles_out.ready;
  assign quat_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[D-2:0], quat_in.valid};
    end
  end

  // Stage 1: halve all components when any magnitude reaches one.
  logic signed [qte_pkg::QUAT_W-1:0] w1, x1, y1, z1;
  logic big;

  function automatic logic is_big(input logic signed [qte_pkg::QUAT_W-1:0] v);
    return !((v > -32'sd1073741824) && (v < 32'sd1073741824));
  endfunction

  assign big = is_big(quat_in.quat_w) || is_big(quat_in.quat_x) ||
               is_big(quat_in.quat_y) || is_big(quat_in.quat_z);

  always_ff @(posedge clk) begin
    if (en) begin
      w1 <= big ? (quat_in.quat_w >>> 1) : quat_in.quat_w;
      x1 <= big ? (quat_in.quat_x >>> 1) : quat_in.quat_x;
      y1 <= big ? (quat_in.quat_y >>> 1) : quat_in.quat_y;
      z1 <= big ? (quat_in.quat_z >>> 1) : quat_in.quat_z;
    end
  end

  // Stage 2: products.
  logic signed [qte_pkg::PROD_W-1:0] ww, xx, yy, zz, wx, yz, wz, xy, wy, zx;

  always_ff @(posedge clk) begin
    if (en) begin
      ww <= qte_pkg::PROD_W'(w1 * w1);
      xx <= qte_pkg::PROD_W'(x1 * x1);
      yy <= qte_pkg::PROD_W'(y1 * y1);
      zz <= qte_pkg::PROD_W'(z1 * z1);
      wx <= qte_pkg::PROD_W'(w1 * x1);
      yz <= qte_pkg::PROD_W'(y1 * z1);
      wz <= qte_pkg::PROD_W'(w1 * z1);
      xy <= qte_pkg::PROD_W'(x1 * y1);
      wy <= qte_pkg::PROD_W'(w1 * y1);
      zx <= qte_pkg::PROD_W'(z1 * x1);
    end
  end

  // Stage 3: vector components of the three angles.
  logic signed [qte_pkg::PROD_W-1:0] ry3, rx3, vy3, vx3, s3;

  always_ff @(posedge clk) begin
    if (en) begin
      ry3 <= (wx + yz) <<< 1;
      rx3 <= ww - xx - yy + zz;
      vy3 <= (wz + xy) <<< 1;
      vx3 <= ww + xx - yy - zz;
      s3  <= (wy - zx) <<< 1;
    end
  end

  // Stage 4: the bit length of the largest magnitude equals that of the OR.
  logic signed [qte_pkg::PROD_W-1:0] ry4, rx4, vy4, vx4, s4;
  logic [qte_pkg::PROD_W-1:0] mr4, mv4;

  function automatic logic [qte_pkg::PROD_W-1:0] mag(
    input logic signed [qte_pkg::PROD_W-1:0] v);
    return v < 0 ? -v : v;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ry4 <= ry3;
      rx4 <= rx3;
      vy4 <= vy3;
      vx4 <= vx3;
      s4  <= s3;
      mr4 <= mag(rx3) | mag(ry3);
      mv4 <= mag(vx3) | mag(vy3) | mag(s3);
    end
  end

  // Stage 5: bit lengths.
  logic signed [qte_pkg::PROD_W-1:0] ry5, rx5, vy5, vx5, s5;
  logic [qte_pkg::LEN_W-1:0] nr5, nv5;

  function automatic logic [qte_pkg::LEN_W-1:0] bit_len(
    input logic [qte_pkg::PROD_W-1:0] m);
    logic [qte_pkg::LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < qte_pkg::PROD_W; i++) begin
      if (m[i]) n = qte_pkg::LEN_W'(i + 1);
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ry5 <= ry4;
      rx5 <= rx4;
      vy5 <= vy4;
      vx5 <= vx4;
      s5  <= s4;
      nr5 <= bit_len(mr4);
      nv5 <= bit_len(mv4);
    end
  end

  // Stage 6: rescale so that the largest magnitude ends at NORM_BITS bits.
  logic signed [qte_pkg::CIN_W-1:0] ry6, rx6, vy6, vx6, s6;

  function automatic logic signed [qte_pkg::CIN_W-1:0] rescale(
    input logic signed [qte_pkg::PROD_W-1:0] v,
    input logic [qte_pkg::LEN_W-1:0] n);
    logic signed [qte_pkg::PROD_W-1:0] r;
    if (n > qte_pkg::LEN_W'(qte_pkg::NORM_BITS)) begin
      r = v >>> (n - qte_pkg::LEN_W'(qte_pkg::NORM_BITS));
    end else begin
      r = v <<< (qte_pkg::LEN_W'(qte_pkg::NORM_BITS) - n);
    end
    return r[qte_pkg::CIN_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ry6 <= rescale(ry5, nr5);
      rx6 <= rescale(rx5, nr5);
      vy6 <= rescale(vy5, nv5);
      vx6 <= rescale(vx5, nv5);
      s6  <= rescale(s5, nv5);
    end
  end

  // Roll and yaw engines run side by side.
  logic signed [qte_pkg::ANG_W-1:0] roll_z, yaw_z, pitch_z;
  logic signed [qte_pkg::CX_W-1:0]  roll_len, yaw_len, pitch_len;

  qte_cordic u_roll (
    .clk   (clk),
    .en    (en),
    .x_in  (rx6),
    .y_in  (ry6),
    .angle (roll_z),
    .len   (roll_len)
  );

  qte_cordic u_yaw (
    .clk   (clk),
    .en    (en),
    .x_in  (vx6),
    .y_in  (vy6),
    .angle (yaw_z),
    .len   (yaw_len)
  );

  // The pitch numerator follows the yaw engine and the length multiply.
  logic signed [qte_pkg::CIN_W-1:0] s_dly [0:DL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      s_dly[0] <= s6;
      for (int i = 1; i < DL; i++) s_dly[i] <= s_dly[i-1];
    end
  end

  // Length of the yaw vector: engine output times the inverse gain.
  logic [qte_pkg::CX_W-2:0]           len_pos;
  logic [qte_pkg::CX_W+31:0]          len_prod;
  logic signed [qte_pkg::CIN_W-1:0]   hyp;

  assign len_pos  = (yaw_len < 0) ? '0 : yaw_len[qte_pkg::CX_W-2:0];
  assign len_prod = (qte_pkg::CX_W+32)'(len_pos) * (qte_pkg::CX_W+32)'(qte_pkg::INV_GAIN_Q32);

  always_ff @(posedge clk) begin
    if (en) begin
      hyp <= len_prod[qte_pkg::CIN_W+31:32];
    end
  end

  qte_cordic u_pitch (
    .clk   (clk),
    .en    (en),
    .x_in  (hyp),
    .y_in  (s_dly[DL-1]),
    .angle (pitch_z),
    .len   (pitch_len)
  );

  // Roll and yaw angles wait for the pitch engine.
  logic signed [qte_pkg::ANG_W-1:0] roll_dly [0:DL-1];
  logic signed [qte_pkg::ANG_W-1:0] yaw_dly  [0:DL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      roll_dly[0] <= roll_z;
      yaw_dly[0]  <= yaw_z;
      for (int i = 1; i < DL; i++) begin
        roll_dly[i] <= roll_dly[i-1];
        yaw_dly[i]  <= yaw_dly[i-1];
      end
    end
  end

  // Output register: clamp pitch to a quarter turn and round half up.
  logic signed [qte_pkg::ANG_W-1:0] pitch_c;

  function automatic logic signed [qte_pkg::ANG_W-1:0] round_angle(
    input logic signed [qte_pkg::ANG_W-1:0] z);
    logic signed [qte_pkg::ANG_W-1:0] t;
    t = z + (64'sd1 <<< (59 - qte_pkg::ANGLE_FRACTION_BITS));
    return t >>> (60 - qte_pkg::ANGLE_FRACTION_BITS);
  endfunction

  logic signed [qte_pkg::ANG_W-1:0] roll_r, pitch_r, yaw_r;

  always_comb begin
    pitch_c = pitch_z;
    if (pitch_z > qte_pkg::HALF_PI_Q60) pitch_c = qte_pkg::HALF_PI_Q60;
    if (pitch_z < -qte_pkg::HALF_PI_Q60) pitch_c = -qte_pkg::HALF_PI_Q60;
    roll_r  = round_angle(roll_dly[DL-1]);
    pitch_r = round_angle(pitch_c);
    yaw_r   = round_angle(yaw_dly[DL-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angles_out.roll_angle  <= roll_r[qte_pkg::ROLL_W-1:0];
      angles_out.pitch_angle <= pitch_r[qte_pkg::PITCH_W-1:0];
      angles_out.yaw_angle   <= yaw_r[qte_pkg::YAW_W-1:0];
    end
  end

  assign angles_out.valid = vld[D-1];

  // The length outputs of the roll and pitch engines are needed only here.
  logic pitch_len_neg;
  logic roll_len_neg;
  assign pitch_len_neg = pitch_len[qte_pkg::CX_W-1];
  assign roll_len_neg  = roll_len[qte_pkg::CX_W-1];

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !angles_out.valid)
    else $error("result presented straight after reset");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    angles_out.valid |-> (angles_out.pitch_angle <= 15'sd12868) &&
                         (angles_out.pitch_angle >= -15'sd12868))
    else $error("pitch beyond a quarter turn");

  a_pitch_len: assert property (@(posedge clk) disable iff (rst)
    vld[D-2] |-> !pitch_len_neg)
    else $error("pitch engine length went negative");

  a_roll_len: assert property (@(posedge clk) disable iff (rst)
    vld[qte_pkg::FRONT_STAGES + qte_pkg::CORDIC_LAT - 1] |-> !roll_len_neg)
    else $error("roll engine length went negative");
`endif

endmodule

[design/qte_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined CORDIC vectoring engine
// One pre-rotation stage and one register stage per micro-rotation.
// ----------------------------------------------------------------------------
module qte_cordic (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [qte_pkg::CIN_W-1:0]    x_in,
  input  logic signed [qte_pkg::CIN_W-1:0]    y_in,
  output logic signed [qte_pkg::ANG_W-1:0]    angle,
  output logic signed [qte_pkg::CX_W-1:0]     len
);

  logic signed [qte_pkg::CX_W-1:0]  xs [0:qte_pkg::CORDIC_STAGES];
  logic signed [qte_pkg::CX_W-1:0]  ys [0:qte_pkg::CORDIC_STAGES];
  logic signed [qte_pkg::ANG_W-1:0] zs [0:qte_pkg::CORDIC_STAGES];
  logic                             zr [0:qte_pkg::CORDIC_STAGES];

  logic signed [qte_pkg::CX_W-1:0]  xe, ye;

  assign xe = qte_pkg::CX_W'(x_in);
  assign ye = qte_pkg::CX_W'(y_in);

  // Vectors in the left half plane are first turned by a quarter turn.
  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          xs[0] <= ye;
          ys[0] <= -xe;
          zs[0] <= qte_pkg::HALF_PI_Q60;
        end else begin
          xs[0] <= -ye;
          ys[0] <= xe;
          zs[0] <= -qte_pkg::HALF_PI_Q60;
        end
      end else begin
        xs[0] <= xe;
        ys[0] <= ye;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < qte_pkg::CORDIC_STAGES; i++) begin : g_iter
    localparam logic signed [qte_pkg::ANG_W-1:0] ATAN_I = qte_pkg::atan_q60(i);
    always_ff @(posedge clk) begin
      if (en) begin
        zr[i+1] <= zr[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_I;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_I;
        end
      end
    end
  end

  assign angle = zr[qte_pkg::CORDIC_STAGES] ? '0 : zs[qte_pkg::CORDIC_STAGES];
  assign len   = zr[qte_pkg::CORDIC_STAGES] ? '0 : xs[qte_pkg::CORDIC_STAGES];

endmodule
